// ===== rtl/core/gfts_pkg.sv =====
// Shared types and constants for the grid field trilinear sampler.
package gfts_pkg;

   // Grid size per axis and the field store geometry.
   localparam int NX_C        = 32;
   localparam int NY_C        = 32;
   localparam int NZ_C        = 32;
   localparam int NODE_W      = 8;
   localparam int ADDR_W      = 15;
   localparam int STORE_DEPTH = 32768;
   localparam int QUEUE_DEPTH = 8;
   localparam int CNT_W       = 4;

   // Input operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_ORIGIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_ORIGIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_X_INV_STEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_INV_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Z_INV_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_TOL   = 3'd6;

   typedef struct packed {
      logic               opcode;
      logic [14:0]        load_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] load_bx;
      logic signed [31:0] load_by;
      logic signed [31:0] load_bz;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_bx;
      logic signed [31:0] out_by;
      logic signed [31:0] out_bz;
   } rsp_type;

   // Position of a query point along one axis.
   typedef struct packed {
      logic [NODE_W-1:0] node0;
      logic [NODE_W-1:0] node1;
      logic [15:0]       frac;
   } axis_pos_type;

   // Commands from the sequencer to each blending lane.
   typedef struct packed {
      logic clear;
      logic push;
      logic mul;
      logic add;
   } lane_ctrl_type;

endpackage

// ===== rtl/core/gfts_axis_map.sv =====
// Maps one query coordinate to a grid node and fraction in two registered stages.
module gfts_axis_map (
   input  logic                     clock,
   input  logic                     en1,
   input  logic                     en2,
   input  logic signed [31:0]       coord,
   input  logic signed [31:0]       origin,
   input  logic [31:0]              inv_step,
   input  logic [15:0]              tol,
   input  logic [gfts_pkg::NODE_W-1:0] n_last,
   output gfts_pkg::axis_pos_type   pos
);
   import gfts_pkg::*;

   logic signed [32:0] diff;
   logic               above_in;
   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;
   logic               above_ff;
   axis_pos_type       pos_in;
   axis_pos_type       pos_ff;
   logic [NODE_W-1:0]  node;
   logic [15:0]        frac;

   // Offset from the origin and scaling into grid units.
   always_comb begin
      diff     = {coord[31], coord} - {origin[31], origin};
      above_in = !diff[32] && (diff != 33'sd0);
      prod_in  = {32'b0, diff[31:0]} * {32'b0, inv_step};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff  <= prod_in;
         above_ff <= above_in;
      end
   end

   // Clamp to the grid, split node and fraction, and snap near nodes.
   always_comb begin
      node = '0;
      frac = '0;
      if (!above_ff) begin
         node = '0;
         frac = '0;
      end else if (prod_ff[63:32] >= {{(32-NODE_W){1'b0}}, n_last}) begin
         node = n_last;
         frac = '0;
      end else begin
         node = prod_ff[32+NODE_W-1:32];
         frac = prod_ff[31:16];
         if (frac <= tol) begin
            node = node + NODE_W'(frac[15]);
            frac = '0;
         end
      end
      pos_in.node0 = node;
      pos_in.node1 = (frac != 16'd0) ? node + NODE_W'(1) : node;
      pos_in.frac  = frac;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// ===== rtl/core/gfts_lerp_lane.sv =====
// One blending lane: collects eight corner values and reduces them pairwise by lerps.
module gfts_lerp_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  gfts_pkg::lane_ctrl_type ctrl,
   input  logic signed [31:0]      push_data,
   input  logic [15:0]             frac,
   output logic signed [31:0]      result
);
   import gfts_pkg::*;

   logic signed [31:0] q_ff [QUEUE_DEPTH];
   logic signed [31:0] q_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic signed [31:0] a_ff;
   logic signed [49:0] prod_ff;
   logic signed [32:0] diff;
   logic signed [16:0] f_s;
   logic signed [49:0] prod_in;
   logic signed [49:0] rnd_full;
   logic signed [33:0] sum;
   logic signed [31:0] sat;

   // Product of the pair difference and the fraction.
   always_comb begin
      diff    = {q_ff[1][31], q_ff[1]} - {q_ff[0][31], q_ff[0]};
      f_s     = $signed({1'b0, frac});
      prod_in = diff * f_s;
   end

   // Rounded step added to the lower value, then saturated.
   always_comb begin
      rnd_full = (prod_ff + 50'sd32768) >>> 16;
      sum      = {{2{a_ff[31]}}, a_ff} + rnd_full[33:0];
      if (sum > 34'sd2147483647) begin
         sat = 32'sh7FFFFFFF;
      end else if (sum < -34'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
   end

   // Queue: values enter at the tail, pairs leave from the head.
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.push) begin
         q_in[cnt_ff[2:0]] = push_data;
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctrl.mul) begin
         for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
            q_in[i] = q_ff[i+2];
         end
         cnt_in = cnt_ff - CNT_W'(2);
      end else if (ctrl.add) begin
         q_in[cnt_ff[2:0]] = sat;
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (ctrl.mul) begin
         prod_ff <= prod_in;
         a_ff    <= q_ff[0];
      end
   end

   assign result = q_ff[0];

endmodule

// ===== rtl/core/grid_field_trilinear_sampler_unit.sv =====
// Top level of the grid field trilinear sampler: store, sequencer, lanes, result merge.
//
// Use: drive req_payload and raise start while busy is low; the transaction is
// taken at that clock edge. A load (opcode 0) writes one 96-bit field entry at
// load_index in that same edge and yields no result; busy stays low, so loads
// can follow each other in every cycle. A query (opcode 1) raises busy while
// states MAP1 and MAP2 map the point to grid nodes (one 32x32 multiply per
// axis), state READ reads the eight corners from the single-port field memory,
// one entry a cycle, state BLEND runs seven lerps in each of three component
// lanes (multiply, then round and add), and state DONE merges the lanes. The
// result appears on rsp_payload with rsp_valid high for exactly one cycle, the
// first cycle in which busy is low again; it cannot be held off, so the
// receiver must take it. A new query is taken only after the last one has
// finished; busy covers the corner reads and the lerps on one multiplier per lane.
// Configuration writes through csr_we, csr_index and csr_wdata take effect at
// once and must be made while the block is idle. Synchronous reset restores the
// register defaults and the idle state; the field store is not cleared, and an
// entry must be loaded before a query reads it.
module grid_field_trilinear_sampler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  gfts_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   output gfts_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_we,
   input  logic [gfts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);
   import gfts_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAP1  = 3'd1;
   localparam logic [2:0] ST_MAP2  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_BLEND = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [NODE_W-1:0] X_LAST = NODE_W'(NX_C - 1);
   localparam logic [NODE_W-1:0] Y_LAST = NODE_W'(NY_C - 1);
   localparam logic [NODE_W-1:0] Z_LAST = NODE_W'(NZ_C - 1);

   logic signed [31:0] x_origin_ff, y_origin_ff, z_origin_ff;
   logic [31:0]        x_inv_ff, y_inv_ff, z_inv_ff;
   logic [15:0]        tol_ff;

   logic [2:0]         state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic               accept;
   logic               en1, en2, rd_req, rd_valid_ff;
   lane_ctrl_type      ctrl;
   axis_pos_type       px, py, pz;
   logic [15:0]        frac_sel;

   logic [95:0]        mem [STORE_DEPTH];
   logic [95:0]        rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [NODE_W-1:0]  ix, iy, iz;

   logic signed [31:0] lane_bx, lane_by, lane_bz;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= '0;
         y_origin_ff <= '0;
         z_origin_ff <= '0;
         x_inv_ff    <= 32'd65536;
         y_inv_ff    <= 32'd65536;
         z_inv_ff    <= 32'd65536;
         tol_ff      <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_X_ORIGIN:   x_origin_ff <= csr_wdata;
            REG_Y_ORIGIN:   y_origin_ff <= csr_wdata;
            REG_Z_ORIGIN:   z_origin_ff <= csr_wdata;
            REG_X_INV_STEP: x_inv_ff    <= csr_wdata;
            REG_Y_INV_STEP: y_inv_ff    <= csr_wdata;
            REG_Z_INV_STEP: z_inv_ff    <= csr_wdata;
            REG_NODE_TOL:   tol_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Query coordinates are held for the mapping stage.
   always_ff @(posedge clock) begin
      if (accept && req_payload.opcode == OP_QUERY) begin
         cx_ff <= req_payload.coord_x;
         cy_ff <= req_payload.coord_y;
         cz_ff <= req_payload.coord_z;
      end
   end

   // Sequencer for one query transaction.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      en1      = 1'b0;
      en2      = 1'b0;
      rd_req   = 1'b0;
      ctrl     = '0;
      ctrl.push = rd_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.opcode == OP_QUERY) begin
               state_in = ST_MAP1;
            end
         end
         ST_MAP1: begin
            en1      = 1'b1;
            state_in = ST_MAP2;
         end
         ST_MAP2: begin
            en2        = 1'b1;
            ctrl.clear = 1'b1;
            step_in    = '0;
            state_in   = ST_READ;
         end
         ST_READ: begin
            if (step_ff == 4'd8) begin
               step_in  = '0;
               state_in = ST_BLEND;
            end else begin
               rd_req  = 1'b1;
               step_in = step_ff + 4'd1;
            end
         end
         ST_BLEND: begin
            ctrl.mul = !step_ff[0];
            ctrl.add = step_ff[0];
            step_in  = step_ff + 4'd1;
            if (step_ff == 4'd13) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         rd_valid_ff <= rd_req;
      end
   end

   // Per-axis mapping units.
   gfts_axis_map u_map_x (
      .clock(clock), .en1(en1), .en2(en2), .coord(cx_ff), .origin(x_origin_ff),
      .inv_step(x_inv_ff), .tol(tol_ff), .n_last(X_LAST), .pos(px)
   );
   gfts_axis_map u_map_y (
      .clock(clock), .en1(en1), .en2(en2), .coord(cy_ff), .origin(y_origin_ff),
      .inv_step(y_inv_ff), .tol(tol_ff), .n_last(Y_LAST), .pos(py)
   );
   gfts_axis_map u_map_z (
      .clock(clock), .en1(en1), .en2(en2), .coord(cz_ff), .origin(z_origin_ff),
      .inv_step(z_inv_ff), .tol(tol_ff), .n_last(Z_LAST), .pos(pz)
   );

   // Corner address: step bits select upper x, y and z nodes, z fastest.
   always_comb begin
      ix = step_ff[2] ? px.node1 : px.node0;
      iy = step_ff[1] ? py.node1 : py.node0;
      iz = step_ff[0] ? pz.node1 : pz.node0;
      rd_addr = ADDR_W'((ADDR_W'(ix) * ADDR_W'(NY_C) + ADDR_W'(iy)) * ADDR_W'(NZ_C)
                        + ADDR_W'(iz));
   end

   // Single-port field store.
   assign mem_we   = accept && (req_payload.opcode == OP_LOAD);
   assign mem_addr = mem_we ? req_payload.load_index : rd_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= {req_payload.load_bx, req_payload.load_by, req_payload.load_bz};
      end else begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Fraction for each lerp level: z pairs, then y, then x.
   always_comb begin
      case (step_ff[3:1])
         3'd0, 3'd1, 3'd2, 3'd3: frac_sel = pz.frac;
         3'd4, 3'd5:             frac_sel = py.frac;
         default:                frac_sel = px.frac;
      endcase
   end

   // One lane per field component.
   gfts_lerp_lane u_lane_bx (
      .clock(clock), .reset(reset), .ctrl(ctrl), .push_data(rd_data_ff[95:64]),
      .frac(frac_sel), .result(lane_bx)
   );
   gfts_lerp_lane u_lane_by (
      .clock(clock), .reset(reset), .ctrl(ctrl), .push_data(rd_data_ff[63:32]),
      .frac(frac_sel), .result(lane_by)
   );
   gfts_lerp_lane u_lane_bz (
      .clock(clock), .reset(reset), .ctrl(ctrl), .push_data(rd_data_ff[31:0]),
      .frac(frac_sel), .result(lane_bz)
   );

   // Merge the lane results into one result transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_ff.out_bx <= lane_bx;
         rsp_ff.out_by <= lane_by;
         rsp_ff.out_bz <= lane_bz;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
